@@ hdl/tcsg_pkg.sv @@
// Package holding the shared types, register codes and level tables of the sound generator.
package tcsg_pkg;

	localparam int QUEUE_DEPTH = 2;

	// Register numbers of the write map.
	localparam logic [3:0] REG_TONE_A_LO = 4'd0;
	localparam logic [3:0] REG_TONE_A_HI = 4'd1;
	localparam logic [3:0] REG_TONE_B_LO = 4'd2;
	localparam logic [3:0] REG_TONE_B_HI = 4'd3;
	localparam logic [3:0] REG_TONE_C_LO = 4'd4;
	localparam logic [3:0] REG_TONE_C_HI = 4'd5;
	localparam logic [3:0] REG_NOISE     = 4'd6;
	localparam logic [3:0] REG_MIXER     = 4'd7;
	localparam logic [3:0] REG_AMP_A     = 4'd8;
	localparam logic [3:0] REG_AMP_B     = 4'd9;
	localparam logic [3:0] REG_AMP_C     = 4'd10;
	localparam logic [3:0] REG_ENV_LO    = 4'd11;
	localparam logic [3:0] REG_ENV_HI    = 4'd12;
	localparam logic [3:0] REG_SHAPE     = 4'd13;

	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// Reciprocal of the mix scaling: ceil(2^36 * 32767 / 196605). With 36 fraction
	// bits the rounding error stays below the smallest step of the exact quotient.
	localparam int         SCALE_SHIFT = 36;
	localparam logic [33:0] SCALE_K    =
		34'(((64'd1 << SCALE_SHIFT) * 64'd32767 + 64'd196604) / 64'd196605);

	typedef struct packed {
		logic       op;
		logic [3:0] reg_addr;
		logic [7:0] reg_data;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  level_a;
		logic [3:0]  level_b;
		logic [3:0]  level_c;
		logic [14:0] mixed_sample;
	} out_item_t;

	// Classified request handed from the front part to the back part.
	typedef struct packed {
		logic       is_tick;
		logic       is_write;
		logic [3:0] reg_addr;
		logic [7:0] reg_data;
	} cmd_t;

	// Amplitude of a 4-bit level from the selected table.
	function automatic logic [15:0] amp_of(input logic model, input logic [3:0] lv);
		logic [15:0] r;
		if (!model) begin
			case (lv)
				4'd0: r = 16'd0;      4'd1: r = 16'd836;    4'd2: r = 16'd1212;
				4'd3: r = 16'd1773;   4'd4: r = 16'd2619;   4'd5: r = 16'd3875;
				4'd6: r = 16'd5397;   4'd7: r = 16'd8823;   4'd8: r = 16'd10392;
				4'd9: r = 16'd16706;  4'd10: r = 16'd23339; 4'd11: r = 16'd29292;
				4'd12: r = 16'd36969; 4'd13: r = 16'd46421; 4'd14: r = 16'd55195;
				default: r = 16'd65535;
			endcase
		end else begin
			case (lv)
				4'd0: r = 16'h0000;  4'd1: r = 16'h00F8;  4'd2: r = 16'h029E;
				4'd3: r = 16'h03F2;  4'd4: r = 16'h0610;  4'd5: r = 16'h090A;
				4'd6: r = 16'h0C3B;  4'd7: r = 16'h1137;  4'd8: r = 16'h1750;
				4'd9: r = 16'h20DF;  4'd10: r = 16'h2C9D; 4'd11: r = 16'h3E55;
				4'd12: r = 16'h54FF; 4'd13: r = 16'h773B; 4'd14: r = 16'hA1DA;
				default: r = 16'hE094;
			endcase
		end
		return r;
	endfunction

endpackage

@@ hdl/three_channel_sound_generator.sv @@
// Top level of the three-channel sound generator.
// One request (a register write or one generator tick) enters per cycle while
// the queue is not full, and yields one result after passing through the front
// queue and then the back part's result register. The sustained rate is one
// request per cycle unless the output stalls, set by the state update.
module three_channel_sound_generator #(
	parameter int QUEUE_DEPTH = tcsg_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  tcsg_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output tcsg_pkg::out_item_t out_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_data
);

	logic           chip_model_q;
	logic           cmd_valid, cmd_take;
	tcsg_pkg::cmd_t cmd;

	// Configuration register.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) chip_model_q <= 1'b0;
		else if (cfg_valid && cfg_ready) chip_model_q <= cfg_data;
	end

	tcsg_front #(.DEPTH(QUEUE_DEPTH)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_item,
		.cmd_valid, .cmd_take, .cmd
	);

	tcsg_back u_back (
		.clk, .arst_n, .chip_model(chip_model_q), .cmd_valid, .cmd_take, .cmd,
		.out_valid, .out_stall, .out_item
	);

endmodule

@@ hdl/tcsg_front.sv @@
// Front part: accepts requests, classifies them and queues them for the back part.
module tcsg_front #(
	parameter int DEPTH = tcsg_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  tcsg_pkg::in_item_t in_item,
	output logic               cmd_valid,
	input  logic               cmd_take,
	output tcsg_pkg::cmd_t     cmd
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	tcsg_pkg::cmd_t       fifo_q [DEPTH];
	logic [AW-1:0]        wp_q, rp_q;
	logic [$clog2(DEPTH+1)-1:0] cnt_q;
	tcsg_pkg::cmd_t       cls;
	logic                 push, pop;

	// Classification of the incoming request.
	always_comb begin
		cls.is_tick  = (in_item.op == tcsg_pkg::OP_TICK);
		cls.is_write = (in_item.op == tcsg_pkg::OP_WRITE);
		cls.reg_addr = in_item.reg_addr;
		cls.reg_data = in_item.reg_data;
	end

	assign in_stall  = (cnt_q == DEPTH[$clog2(DEPTH+1)-1:0]);
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (cnt_q != '0);
	assign pop       = cmd_valid && cmd_take;
	assign cmd       = fifo_q[rp_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) fifo_q[wp_q] <= cls;
	end

	// Queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (pop)  rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + {{($clog2(DEPTH+1)-1){1'b0}}, push} -
				{{($clog2(DEPTH+1)-1){1'b0}}, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH) else $error("queue count out of range");
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> cmd_valid) else $error("stall while queue empty");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> !pop) else $error("pop from empty queue");

endmodule

@@ hdl/tcsg_back.sv @@
// Back part: generator state, register writes, ticks and output levels.
module tcsg_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                chip_model,
	input  logic                cmd_valid,
	output logic                cmd_take,
	input  tcsg_pkg::cmd_t      cmd,
	output logic                out_valid,
	input  logic                out_stall,
	output tcsg_pkg::out_item_t out_item
);

	logic [11:0] tp_q [3];
	logic [11:0] tc_q [3];
	logic [4:0]  np_q;
	logic [5:0]  mix_q;
	logic [4:0]  fl_q [3];
	logic [15:0] ep_q, ec_q;
	logic [3:0]  sh_q;
	logic [2:0]  tb_q;
	logic [5:0]  nc_q;
	logic [16:0] ns_q;
	logic signed [6:0] ev_q;
	logic        ef_q;

	logic [11:0] tp_d [3];
	logic [11:0] tc_d [3];
	logic [4:0]  np_d;
	logic [5:0]  mix_d;
	logic [4:0]  fl_d [3];
	logic [15:0] ep_d, ec_d;
	logic [3:0]  sh_d;
	logic [2:0]  tb_d;
	logic [5:0]  nc_d;
	logic [16:0] ns_d;
	logic signed [6:0] ev_d, v;
	logic        ef_d, f;
	logic [11:0] tinc;
	logic [5:0]  ninc;
	logic [15:0] einc;
	logic [3:0]  lv [3];
	logic [4:0]  ecl;
	logic        tone_ok, noise_ok;

	// Level stage: levels and the amplitude sum, ahead of the scaling multiply.
	logic        v_s1;
	logic [3:0]  la_s1, lb_s1, lc_s1;
	logic [17:0] sum_s1;
	logic        step;

	// Output stage is taken when empty or being drained.
	assign out_valid = v_s1;
	assign step      = !v_s1 || !out_stall;
	assign cmd_take  = step;

	// Next state for one request.
	always_comb begin
		tp_d = tp_q; tc_d = tc_q; np_d = np_q; mix_d = mix_q; fl_d = fl_q;
		ep_d = ep_q; ec_d = ec_q; sh_d = sh_q; tb_d = tb_q; nc_d = nc_q;
		ns_d = ns_q; ev_d = ev_q; ef_d = ef_q;
		v = ev_q; f = ef_q; tinc = '0; ninc = '0; einc = '0;
		if (cmd.is_write) begin
			case (cmd.reg_addr)
				tcsg_pkg::REG_TONE_A_LO: tp_d[0][7:0] = cmd.reg_data;
				tcsg_pkg::REG_TONE_B_LO: tp_d[1][7:0] = cmd.reg_data;
				tcsg_pkg::REG_TONE_C_LO: tp_d[2][7:0] = cmd.reg_data;
				tcsg_pkg::REG_TONE_A_HI: tp_d[0][11:8] = cmd.reg_data[3:0];
				tcsg_pkg::REG_TONE_B_HI: tp_d[1][11:8] = cmd.reg_data[3:0];
				tcsg_pkg::REG_TONE_C_HI: tp_d[2][11:8] = cmd.reg_data[3:0];
				tcsg_pkg::REG_NOISE:     np_d = cmd.reg_data[4:0];
				tcsg_pkg::REG_MIXER:     mix_d = cmd.reg_data[5:0];
				tcsg_pkg::REG_AMP_A:     fl_d[0] = cmd.reg_data[4:0];
				tcsg_pkg::REG_AMP_B:     fl_d[1] = cmd.reg_data[4:0];
				tcsg_pkg::REG_AMP_C:     fl_d[2] = cmd.reg_data[4:0];
				tcsg_pkg::REG_ENV_LO:    ep_d[7:0] = cmd.reg_data;
				tcsg_pkg::REG_ENV_HI:    ep_d[15:8] = cmd.reg_data;
				tcsg_pkg::REG_SHAPE: begin
					sh_d = cmd.reg_data[3:0];
					ec_d = '0;
					ef_d = 1'b1;
					ev_d = cmd.reg_data[2] ? -7'sd1 : 7'sd32;
				end
				default: ;
			endcase
		end else begin
			// Tone dividers.
			for (int i = 0; i < 3; i++) begin
				tinc = tc_q[i] + 12'd1;
				if ({1'b0, tinc} >= {1'b0, tp_q[i]} || tc_q[i] == 12'hFFF) begin
					tc_d[i] = '0;
					tb_d[i] = ~tb_q[i];
				end else begin
					tc_d[i] = tinc;
				end
			end
			// Noise divider and shift register.
			ninc = nc_q + 6'd1;
			if (!ninc[0] && ({1'b0, ninc} >= {1'b0, np_q, 1'b0} || nc_q == 6'h3F)) begin
				nc_d = '0;
				ns_d = {ns_q[15:0], 1'b1} ^ {16'd0, ns_q[16] ^ ns_q[13]};
			end else begin
				nc_d = ninc;
			end
			// Envelope step on a zero count.
			if (ec_q == '0) begin
				case (sh_q)
					4'd8:  v = (v - 7'sd1) & 7'sd31;
					4'd12: v = (v + 7'sd1) & 7'sd31;
					4'd10: begin
						if (f) begin
							v = v - 7'sd1;
							if (v < 0) begin f = 1'b0; v = 7'sd0; end
						end else begin
							v = v + 7'sd1;
							if (v >= 7'sd32) begin f = 1'b1; v = 7'sd31; end
						end
					end
					4'd11: if (f) begin
						v = v - 7'sd1;
						if (v < 0) begin f = 1'b0; v = 7'sd31; end
					end
					4'd13: if (f) begin
						v = v + 7'sd1;
						if (v >= 7'sd32) begin f = 1'b0; v = 7'sd31; end
					end
					4'd14: begin
						if (!f) begin
							v = v - 7'sd1;
							if (v < 0) begin f = 1'b1; v = 7'sd0; end
						end else begin
							v = v + 7'sd1;
							if (v >= 7'sd32) begin f = 1'b0; v = 7'sd31; end
						end
					end
					4'd4, 4'd5, 4'd6, 4'd7, 4'd15: if (f) begin
						v = v + 7'sd1;
						if (v >= 7'sd32) begin f = 1'b0; v = 7'sd0; end
					end
					default: if (f) begin
						v = v - 7'sd1;
						if (v <= 0) begin f = 1'b0; v = 7'sd0; end
					end
				endcase
				ev_d = v;
				ef_d = f;
			end
			einc = ec_q + 16'd1;
			ec_d = (einc >= ep_q || ec_q == 16'hFFFF) ? '0 : einc;
		end
		// Channel levels from the new state.
		ecl = (ev_d < 0) ? 5'd0 : (ev_d > 7'sd31) ? 5'd31 : ev_d[4:0];
		for (int i = 0; i < 3; i++) begin
			tone_ok  = tb_d[i] || mix_d[i];
			noise_ok = ns_d[0] || mix_d[i+3];
			if (!(tone_ok && noise_ok))  lv[i] = '0;
			else if (!fl_d[i][4])        lv[i] = fl_d[i][3:0];
			else                         lv[i] = ecl[4:1];
		end
	end

	// Generator state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				tp_q[i] <= '0; tc_q[i] <= '0; fl_q[i] <= '0;
			end
			np_q <= '0; mix_q <= '0; ep_q <= '0; ec_q <= '0; sh_q <= '0;
			tb_q <= '0; nc_q <= '0; ns_q <= '0; ev_q <= 7'sd32; ef_q <= 1'b1;
			v_s1 <= 1'b0;
		end else if (step) begin
			if (cmd_valid) begin
				tp_q <= tp_d; tc_q <= tc_d; np_q <= np_d; mix_q <= mix_d;
				fl_q <= fl_d; ep_q <= ep_d; ec_q <= ec_d; sh_q <= sh_d;
				tb_q <= tb_d; nc_q <= nc_d; ns_q <= ns_d; ev_q <= ev_d; ef_q <= ef_d;
			end
			v_s1 <= cmd_valid;
		end
	end

	// Result register with the table sum.
	always_ff @(posedge clk) begin
		if (step && cmd_valid) begin
			la_s1  <= lv[0];
			lb_s1  <= lv[1];
			lc_s1  <= lv[2];
			sum_s1 <= 18'(tcsg_pkg::amp_of(chip_model, lv[0])) +
				18'(tcsg_pkg::amp_of(chip_model, lv[1])) +
				18'(tcsg_pkg::amp_of(chip_model, lv[2]));
		end
	end

	// Scaling: sum*32767/196605 is taken as sum times a rounded-up reciprocal
	// with 36 fraction bits; the quotient is exact over the whole sum range.
	logic [51:0] prod;
	logic [14:0] scaled;
	assign prod   = {34'd0, sum_s1} * {18'd0, tcsg_pkg::SCALE_K};
	assign scaled = prod[50:36];
	always_comb begin
		out_item.level_a      = la_s1;
		out_item.level_b      = lb_s1;
		out_item.level_c      = lc_s1;
		out_item.mixed_sample = scaled;
	end

	a_env_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ev_q >= -7'sd1) && (ev_q <= 7'sd32)) else $error("envelope level out of range");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(la_s1)) else $error("result lost");
	a_shape_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(step && cmd_valid && cmd.is_write && cmd.reg_addr == tcsg_pkg::REG_SHAPE)
		|=> (ec_q == '0) && ef_q) else $error("envelope not restarted");

endmodule

@@ test/tb.sv @@
// Testbench of the three-channel sound generator: predicted levels and samples checked in order.
`timescale 1ns / 1ps

// Holds the predicted generator state and the queue of expected results.
class level_scoreboard;
	bit        model;
	bit [11:0] tperiod [3];
	bit [4:0]  nperiod;
	bit [5:0]  mixer;
	bit [4:0]  amp [3];
	bit [15:0] eperiod;
	bit [3:0]  shape;
	bit [11:0] tcount [3];
	bit [2:0]  tbits;
	bit [5:0]  ncount;
	bit [16:0] nshift;
	bit [15:0] ecount;
	int        elevel;
	bit        efirst;
	tcsg_pkg::out_item_t pending[$];
	int        errors;

	function void clear();
		model = 0; nperiod = 0; mixer = 0; eperiod = 0; shape = 0;
		tbits = 0; ncount = 0; nshift = 0; ecount = 0; elevel = 32; efirst = 1;
		for (int i = 0; i < 3; i++) begin
			tperiod[i] = 0; amp[i] = 0; tcount[i] = 0;
		end
		pending.delete(); errors = 0;
	endfunction

	function void env_step();
		int v;
		bit f;
		v = elevel; f = efirst;
		case (shape)
			4'd8: v = (v - 1) & 31;
			4'd12: v = (v + 1) & 31;
			4'd10: if (f) begin
				v--; if (v < 0) begin f = 0; v = 0; end
			end else begin
				v++; if (v >= 32) begin f = 1; v = 31; end
			end
			4'd11: if (f) begin
				v--; if (v < 0) begin f = 0; v = 31; end
			end
			4'd13: if (f) begin
				v++; if (v >= 32) begin f = 0; v = 31; end
			end
			4'd14: if (!f) begin
				v--; if (v < 0) begin f = 1; v = 0; end
			end else begin
				v++; if (v >= 32) begin f = 0; v = 31; end
			end
			4'd4, 4'd5, 4'd6, 4'd7, 4'd15: if (f) begin
				v++; if (v >= 32) begin f = 0; v = 0; end
			end
			default: if (f) begin
				v--; if (v <= 0) begin f = 0; v = 0; end
			end
		endcase
		elevel = v; efirst = f;
	endfunction

	function bit [15:0] table_amp(bit [3:0] lv);
		bit [15:0] t16 [16] = '{0, 836, 1212, 1773, 2619, 3875, 5397, 8823, 10392,
			16706, 23339, 29292, 36969, 46421, 55195, 65535};
		bit [15:0] t32 [16] = '{16'h0, 16'hF8, 16'h29E, 16'h3F2, 16'h610, 16'h90A,
			16'hC3B, 16'h1137, 16'h1750, 16'h20DF, 16'h2C9D, 16'h3E55, 16'h54FF,
			16'h773B, 16'hA1DA, 16'hE094};
		return model ? t32[lv] : t16[lv];
	endfunction

	// Applies one accepted request and queues the result it yields.
	function void note_request(tcsg_pkg::in_item_t it);
		bit [3:0] lv [3];
		bit [63:0] sum;
		bit tok, nok;
		int e;
		tcsg_pkg::out_item_t r;
		if (it.op == tcsg_pkg::OP_WRITE) begin
			case (it.reg_addr)
				tcsg_pkg::REG_TONE_A_LO, tcsg_pkg::REG_TONE_B_LO, tcsg_pkg::REG_TONE_C_LO:
					tperiod[it.reg_addr >> 1][7:0] = it.reg_data;
				tcsg_pkg::REG_TONE_A_HI, tcsg_pkg::REG_TONE_B_HI, tcsg_pkg::REG_TONE_C_HI:
					tperiod[it.reg_addr >> 1][11:8] = it.reg_data[3:0];
				tcsg_pkg::REG_NOISE: nperiod = it.reg_data[4:0];
				tcsg_pkg::REG_MIXER: mixer = it.reg_data[5:0];
				tcsg_pkg::REG_AMP_A, tcsg_pkg::REG_AMP_B, tcsg_pkg::REG_AMP_C:
					amp[it.reg_addr - tcsg_pkg::REG_AMP_A] = it.reg_data[4:0];
				tcsg_pkg::REG_ENV_LO: eperiod[7:0] = it.reg_data;
				tcsg_pkg::REG_ENV_HI: eperiod[15:8] = it.reg_data;
				tcsg_pkg::REG_SHAPE: begin
					shape = it.reg_data[3:0];
					ecount = 0; efirst = 1; elevel = shape[2] ? -1 : 32;
				end
				default: ;
			endcase
		end else begin
			for (int i = 0; i < 3; i++) begin
				tcount[i]++;
				if (tcount[i] >= tperiod[i]) begin
					tcount[i] = 0; tbits[i] = ~tbits[i];
				end
			end
			ncount++;
			if (!ncount[0] && ncount >= {nperiod, 1'b0}) begin
				ncount = 0;
				nshift = {nshift[15:0], 1'b1} ^ {16'd0, nshift[16] ^ nshift[13]};
			end
			if (ecount == 0) env_step();
			ecount++;
			if (ecount >= eperiod) ecount = 0;
		end
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			tok = tbits[i] | mixer[i];
			nok = nshift[0] | mixer[i + 3];
			if (!(tok && nok)) lv[i] = 0;
			else if (!amp[i][4]) lv[i] = amp[i][3:0];
			else begin
				e = elevel;
				if (e < 0) e = 0;
				if (e > 31) e = 31;
				lv[i] = 4'(e >> 1);
			end
			sum += table_amp(lv[i]);
		end
		r.level_a = lv[0]; r.level_b = lv[1]; r.level_c = lv[2];
		r.mixed_sample = 15'((sum * 64'd32767) / (64'd65535 * 64'd3));
		pending.push_back(r);
	endfunction

	// Compares one accepted result with the oldest prediction.
	function void check_result(tcsg_pkg::out_item_t got);
		tcsg_pkg::out_item_t want;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result %h", $time, got);
			errors++;
			return;
		end
		want = pending.pop_front();
		if (got.level_a !== want.level_a)
			$display("%0t: level_a expected %0d actual %0d", $time, want.level_a, got.level_a);
		if (got.level_b !== want.level_b)
			$display("%0t: level_b expected %0d actual %0d", $time, want.level_b, got.level_b);
		if (got.level_c !== want.level_c)
			$display("%0t: level_c expected %0d actual %0d", $time, want.level_c, got.level_c);
		if (got.mixed_sample !== want.mixed_sample)
			$display("%0t: mixed_sample expected %0d actual %0d", $time,
				want.mixed_sample, got.mixed_sample);
		if (got !== want) errors++;
	endfunction
endclass

module tb;
	logic      clk = 0;
	logic      arst_n = 0;
	logic      in_valid = 0;
	logic      in_stall;
	tcsg_pkg::in_item_t  in_item = '0;
	logic      out_valid;
	logic      out_stall = 0;
	tcsg_pkg::out_item_t out_item;
	logic      cfg_valid = 0;
	logic      cfg_ready;
	logic      cfg_data = 0;

	level_scoreboard board;
	int  send_idle = 0;
	int  recv_stall = 0;
	longint cycles = 0;

	three_channel_sound_generator DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// Cycle limit guarding against a hung handshake.
	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Result side: check at the rising edge, choose the next stall at the falling edge.
	always @(posedge clk)
		if (arst_n && out_valid && !out_stall) board.check_result(out_item);

	always @(negedge clk)
		out_stall <= ($urandom_range(99) < recv_stall);

	// Sends one request, idling beforehand as the current phase asks. Valid is
	// left high on return so that requests can follow back to back.
	task automatic send(input logic op, input logic [3:0] a, input logic [7:0] d);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		in_item <= '{op: op, reg_addr: a, reg_data: d};
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
		board.note_request(in_item);
		@(negedge clk);
	endtask

	task automatic drain();
		int n;
		n = 0;
		in_valid <= 0;
		while (board.pending.size() != 0 && n < 20000) begin
			@(negedge clk); n++;
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic set_model(input logic m);
		drain();
		cfg_valid <= 1;
		cfg_data <= m;
		forever begin
			@(posedge clk);
			if (cfg_ready) break;
		end
		board.model = m;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	// Random request: mostly ticks, writes biased towards short periods.
	task automatic random_request();
		logic [3:0] a;
		logic [7:0] d;
		a = 4'($urandom_range(15));
		d = 8'($urandom_range(255));
		if ($urandom_range(99) < 65) send(tcsg_pkg::OP_TICK, a, d);
		else begin
			if ((a == tcsg_pkg::REG_TONE_A_HI || a == tcsg_pkg::REG_TONE_B_HI ||
				a == tcsg_pkg::REG_TONE_C_HI || a == tcsg_pkg::REG_ENV_HI) &&
				$urandom_range(3) != 0) d = 0;
			if ((a == tcsg_pkg::REG_ENV_LO || a == tcsg_pkg::REG_TONE_A_LO) &&
				$urandom_range(1)) d = d & 8'h07;
			send(tcsg_pkg::OP_WRITE, a, d);
		end
	endtask

	initial begin
		board = new();
		board.clear();
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed part, with chip model 1: extremes, every register, envelope start levels.
		set_model(1);
		send(tcsg_pkg::OP_TICK, 4'd0, 8'd0);
		send(tcsg_pkg::OP_WRITE, tcsg_pkg::REG_AMP_A, 8'hFF);
		send(tcsg_pkg::OP_WRITE, tcsg_pkg::REG_AMP_B, 8'h0F);
		send(tcsg_pkg::OP_WRITE, tcsg_pkg::REG_AMP_C, 8'h10);
		send(tcsg_pkg::OP_WRITE, tcsg_pkg::REG_MIXER, 8'hFF);
		send(tcsg_pkg::OP_WRITE, tcsg_pkg::REG_SHAPE, 8'h04);
		send(tcsg_pkg::OP_TICK, 4'd15, 8'hFF);
		send(tcsg_pkg::OP_WRITE, tcsg_pkg::REG_SHAPE, 8'hFB);
		send(tcsg_pkg::OP_WRITE, tcsg_pkg::REG_TONE_A_LO, 8'hFF);
		send(tcsg_pkg::OP_WRITE, tcsg_pkg::REG_TONE_A_HI, 8'hFF);
		send(tcsg_pkg::OP_WRITE, tcsg_pkg::REG_TONE_B_LO, 8'h01);
		send(tcsg_pkg::OP_WRITE, tcsg_pkg::REG_TONE_B_HI, 8'h00);
		send(tcsg_pkg::OP_WRITE, tcsg_pkg::REG_TONE_C_LO, 8'h02);
		send(tcsg_pkg::OP_WRITE, tcsg_pkg::REG_TONE_C_HI, 8'h00);
		send(tcsg_pkg::OP_WRITE, tcsg_pkg::REG_NOISE, 8'hFF);
		send(tcsg_pkg::OP_WRITE, tcsg_pkg::REG_ENV_LO, 8'h01);
		send(tcsg_pkg::OP_WRITE, tcsg_pkg::REG_ENV_HI, 8'h00);
		send(tcsg_pkg::OP_WRITE, 4'd14, 8'hAA);
		send(tcsg_pkg::OP_WRITE, 4'd15, 8'h55);
		send(tcsg_pkg::OP_WRITE, tcsg_pkg::REG_MIXER, 8'h00);
		repeat (4) send(tcsg_pkg::OP_TICK, 4'd0, 8'd0);
		set_model(0);

		// Random phases with differing idle patterns and chip models.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 67; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 67; end
				default: begin send_idle = 13; recv_stall = 13; end
			endcase
			set_model(ph[0]);
			for (int i = 0; i < 210; i++) begin
				random_request();
				if (i == 100) drain();
			end
		end

		drain();
		if (board.errors == 0 && board.pending.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
